[hdl/som_pkg.sv]
// Shared types, constants and codes for the servo output mixer.
// Used by every module of the mixer; depends on nothing else.
package som_pkg;

    // Field widths.
    localparam int CMD_W      = 12;
    localparam int PULSE_W    = 12;
    localparam int TERM_W     = 14;
    localparam int SUM_W      = 15;
    localparam int CFG_W      = 36;
    localparam int CFG_IDX_W  = 3;

    // Servo counts: limit lanes held in the registers, mix slots a mode can drive.
    localparam int SERVO_COUNT_DEF = 6;
    localparam int LANE_COUNT      = 6;
    localparam int MIX_SLOTS       = 5;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // Quadcopter divide by five, done as a multiply by a rounded-up reciprocal.
    localparam int QUAD_DIV   = 5;
    localparam int QUAD_SHIFT = 16;
    localparam int QUAD_RECIP = ((1 << QUAD_SHIFT) + QUAD_DIV - 1) / QUAD_DIV;

    // Register reset values, three 12-bit lanes each.
    localparam logic [CFG_W-1:0] NEUTRAL_RST = 36'd25171969500;
    localparam logic [CFG_W-1:0] MIN_RST     = 36'd16781313000;
    localparam logic [CFG_W-1:0] MAX_RST     = 36'd33562626000;

    typedef enum logic [1:0] {
        MODE_AILERON     = 2'd0,
        MODE_DELTA_PLUS  = 2'd1,
        MODE_DELTA_MINUS = 2'd2,
        MODE_QUAD        = 2'd3
    } t_mix_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIX_MODE  = 3'd0,
        CFG_REVERSE   = 3'd1,
        CFG_NEUTRAL_A = 3'd2,
        CFG_NEUTRAL_B = 3'd3,
        CFG_MIN_A     = 3'd4,
        CFG_MIN_B     = 3'd5,
        CFG_MAX_A     = 3'd6,
        CFG_MAX_B     = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [CMD_W-1:0] pitch_cmd;
        logic signed [CMD_W-1:0] roll_cmd;
        logic signed [CMD_W-1:0] yaw_cmd;
        logic signed [CMD_W-1:0] throttle_cmd;
    } t_cmd_set;

    typedef struct packed {
        logic [PULSE_W-1:0] pulse_0;
        logic [PULSE_W-1:0] pulse_1;
        logic [PULSE_W-1:0] pulse_2;
        logic [PULSE_W-1:0] pulse_3;
        logic [PULSE_W-1:0] pulse_4;
        logic [PULSE_W-1:0] pulse_5;
    } t_pulse_set;

    // One classified item: signed mix term per slot and which slots are driven.
    typedef struct packed {
        logic [MIX_SLOTS-1:0]             drive;
        logic [MIX_SLOTS-1:0][TERM_W-1:0] term;
    } t_mix_item;

    // Per-servo limits, lane 0 lowest.
    typedef struct packed {
        logic [LANE_COUNT-1:0][PULSE_W-1:0] neutral;
        logic [LANE_COUNT-1:0][PULSE_W-1:0] min;
        logic [LANE_COUNT-1:0][PULSE_W-1:0] max;
    } t_limits;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

[hdl/som_front.sv]
// Front part of the mixer: takes command beats and works out the mix terms.
// Depends on som_pkg.
module som_front (
    input  logic                 i_valid,
    input  som_pkg::t_cmd_set    i_cmd,
    input  som_pkg::t_mix_mode   i_mix_mode,
    input  logic [4:0]           i_reverse,
    input  som_pkg::t_q_status   i_q_status,
    output logic                 o_stall,
    output logic                 o_push,
    output som_pkg::t_mix_item   o_item
);

    // Signed divide by five, truncating toward zero, via a reciprocal multiply.
    function automatic logic signed [som_pkg::TERM_W-1:0] f_div5(
        input logic signed [som_pkg::CMD_W-1:0] x
    );
        logic [som_pkg::CMD_W-1:0]                   mag;
        logic [som_pkg::CMD_W+som_pkg::QUAD_SHIFT-1:0] prod;
        logic [som_pkg::TERM_W-1:0]                  q;
        mag  = x[som_pkg::CMD_W-1] ? som_pkg::CMD_W'(-x) : som_pkg::CMD_W'(x);
        prod = (som_pkg::CMD_W+som_pkg::QUAD_SHIFT)'(mag)
             * (som_pkg::CMD_W+som_pkg::QUAD_SHIFT)'(som_pkg::QUAD_RECIP);
        q    = som_pkg::TERM_W'(prod >> som_pkg::QUAD_SHIFT);
        return x[som_pkg::CMD_W-1] ? -q : q;
    endfunction

    logic signed [som_pkg::TERM_W-1:0] e;
    logic signed [som_pkg::TERM_W-1:0] a;
    logic signed [som_pkg::TERM_W-1:0] y;
    logic signed [som_pkg::TERM_W-1:0] m;
    logic signed [som_pkg::TERM_W-1:0] e5;
    logic signed [som_pkg::TERM_W-1:0] a5;
    logic signed [som_pkg::TERM_W-1:0] y5;

    // Accept whenever the queue has room.
    assign o_stall = i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full;

    // Sign-extend the commands to the term width.
    assign e = som_pkg::TERM_W'(i_cmd.pitch_cmd);
    assign a = som_pkg::TERM_W'(i_cmd.roll_cmd);
    assign y = som_pkg::TERM_W'(i_cmd.yaw_cmd);
    assign m = som_pkg::TERM_W'(i_cmd.throttle_cmd);

    assign e5 = f_div5(i_cmd.pitch_cmd);
    assign a5 = f_div5(i_cmd.roll_cmd);
    assign y5 = f_div5(i_cmd.yaw_cmd);

    // Mode decode: terms and drive mask per slot.
    always_comb begin
        o_item = '0;
        unique case (i_mix_mode)
            som_pkg::MODE_DELTA_PLUS: begin
                o_item.term[0] = i_reverse[0] ? a + e : -a - e;
                o_item.term[1] = i_reverse[1] ? a - e : -a + e;
                o_item.term[3] = i_reverse[3] ? -m : m;
                o_item.drive   = 5'b01011;
            end
            som_pkg::MODE_DELTA_MINUS: begin
                o_item.term[0] = i_reverse[0] ? a - e : -a + e;
                o_item.term[1] = i_reverse[1] ? a + e : -a - e;
                o_item.term[3] = i_reverse[3] ? -m : m;
                o_item.drive   = 5'b01011;
            end
            som_pkg::MODE_QUAD: begin
                o_item.term[0] = m + a5 + y5;
                o_item.term[1] = m + e5 - y5;
                o_item.term[2] = m - a5 + y5;
                o_item.term[3] = m - e5 - y5;
                o_item.drive   = 5'b01111;
            end
            som_pkg::MODE_AILERON: begin
                o_item.term[0] = i_reverse[0] ? -a : a;
                o_item.term[1] = i_reverse[1] ? a : -a;
                o_item.term[2] = i_reverse[2] ? -e : e;
                o_item.term[3] = i_reverse[3] ? -m : m;
                o_item.term[4] = i_reverse[4] ? y : -y;
                o_item.drive   = 5'b11111;
            end
        endcase
    end

endmodule

[hdl/som_queue.sv]
// Short queue of classified items between the front and back parts.
// Depends on som_pkg.
module som_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  som_pkg::t_mix_item  i_item,
    input  logic                i_pop,
    output som_pkg::t_mix_item  o_item,
    output som_pkg::t_q_status  o_status
);

    localparam int DEPTH = som_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    som_pkg::t_mix_item r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_item         = r_mem[r_rd_ptr];

    // Pointer wrap.
    assign n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

[hdl/som_back.sv]
// Back part of the mixer: adds neutrals, clamps, holds pulses and drives the output.
// Depends on som_pkg.
module som_back #(
    parameter int SERVO_COUNT = som_pkg::SERVO_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  som_pkg::t_q_status  i_q_status,
    input  som_pkg::t_mix_item  i_item,
    input  som_pkg::t_limits    i_limits,
    input  logic                i_stall,
    output logic                o_pop,
    output logic                o_valid,
    output som_pkg::t_pulse_set o_data
);

    logic [SERVO_COUNT-1:0][som_pkg::PULSE_W-1:0] r_held;
    logic [SERVO_COUNT-1:0][som_pkg::PULSE_W-1:0] n_held;
    logic                                         r_valid;
    logic [som_pkg::LANE_COUNT-1:0][som_pkg::PULSE_W-1:0] pulse_arr;

    // Take the next item once the output beat is free or leaving.
    assign o_pop   = !i_q_status.empty && (!r_valid || !i_stall);
    assign o_valid = r_valid;

    // Per-servo sum and clamp: maximum first, then minimum.
    for (genvar g = 0; g < SERVO_COUNT; g++) begin : g_servo
        logic signed [som_pkg::SUM_W-1:0] sum;
        logic signed [som_pkg::SUM_W-1:0] hi;
        logic signed [som_pkg::SUM_W-1:0] lo;
        logic signed [som_pkg::SUM_W-1:0] clip_hi;
        logic                             drv;
        logic signed [som_pkg::SUM_W-1:0] term;
        logic signed [som_pkg::SUM_W-1:0] neutral;

        if (g < som_pkg::MIX_SLOTS) begin : g_slot
            assign drv  = i_item.drive[g];
            assign term = som_pkg::SUM_W'($signed(i_item.term[g]));
        end else begin : g_noslot
            assign drv  = 1'b0;
            assign term = '0;
        end

        if (g < som_pkg::LANE_COUNT) begin : g_lane
            assign neutral = $signed({3'b000, i_limits.neutral[g]});
            assign hi      = $signed({3'b000, i_limits.max[g]});
            assign lo      = $signed({3'b000, i_limits.min[g]});
        end else begin : g_nolane
            assign neutral = '0;
            assign hi      = '0;
            assign lo      = '0;
        end

        assign sum     = drv ? term + neutral : $signed({3'b000, r_held[g]});
        assign clip_hi = (sum > hi) ? hi : sum;
        assign n_held[g] = (clip_hi < lo) ? lo[som_pkg::PULSE_W-1:0]
                                          : clip_hi[som_pkg::PULSE_W-1:0];
    end

    // Held pulses and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_held  <= n_held;
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output fields; fields without a servo read zero.
    for (genvar k = 0; k < som_pkg::LANE_COUNT; k++) begin : g_out
        if (k < SERVO_COUNT) begin : g_have
            assign pulse_arr[k] = r_held[k];
        end else begin : g_none
            assign pulse_arr[k] = '0;
        end
    end

    assign o_data.pulse_0 = pulse_arr[0];
    assign o_data.pulse_1 = pulse_arr[1];
    assign o_data.pulse_2 = pulse_arr[2];
    assign o_data.pulse_3 = pulse_arr[3];
    assign o_data.pulse_4 = pulse_arr[4];
    assign o_data.pulse_5 = pulse_arr[5];

endmodule

[hdl/servo_output_mixer_core.sv]
// Top level of the servo output mixer: configuration registers and part wiring.
// Depends on som_pkg, som_front, som_queue and som_back.
//
//  Channel   Direction  Signals                              Beat
//  command   in         i_valid, o_stall, i_data             pitch, roll, yaw, throttle
//  pulses    out        o_valid, i_stall, o_data             six clamped pulse widths
//  config    in         i_cfg_we, i_cfg_idx, i_cfg_wdata     one register write
//
// One command beat is taken per cycle while o_stall is low; a pulse beat leaves
// through the queue entry and then the clamp into the held registers.
// The front multiplies by the reciprocal of five and the back does one add
// and two compares per servo, so nothing iterates.
// Reset is synchronous and active low; it restores the register defaults and
// clears the held pulses. A stalled pulse beat holds; o_stall rises once the
// two-entry queue is full.
module servo_output_mixer_core #(
    parameter int SERVO_COUNT = som_pkg::SERVO_COUNT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  som_pkg::t_cmd_set                  i_data,
    output logic                               o_valid,
    input  logic                               i_stall,
    output som_pkg::t_pulse_set                o_data,
    input  logic                               i_cfg_we,
    input  logic [som_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [som_pkg::CFG_W-1:0]          i_cfg_wdata
);

    som_pkg::t_mix_mode         r_mix_mode;
    logic [4:0]                 r_reverse;
    logic [som_pkg::CFG_W-1:0]  r_neutral_a;
    logic [som_pkg::CFG_W-1:0]  r_neutral_b;
    logic [som_pkg::CFG_W-1:0]  r_min_a;
    logic [som_pkg::CFG_W-1:0]  r_min_b;
    logic [som_pkg::CFG_W-1:0]  r_max_a;
    logic [som_pkg::CFG_W-1:0]  r_max_b;

    som_pkg::t_limits    limits;
    som_pkg::t_q_status  q_status;
    som_pkg::t_mix_item  push_item;
    som_pkg::t_mix_item  head_item;
    logic                push;
    logic                pop;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mix_mode  <= som_pkg::MODE_AILERON;
            r_reverse   <= '0;
            r_neutral_a <= som_pkg::NEUTRAL_RST;
            r_neutral_b <= som_pkg::NEUTRAL_RST;
            r_min_a     <= som_pkg::MIN_RST;
            r_min_b     <= som_pkg::MIN_RST;
            r_max_a     <= som_pkg::MAX_RST;
            r_max_b     <= som_pkg::MAX_RST;
        end else if (i_cfg_we) begin
            unique case (som_pkg::t_cfg_idx'(i_cfg_idx))
                som_pkg::CFG_MIX_MODE:  r_mix_mode  <= som_pkg::t_mix_mode'(i_cfg_wdata[1:0]);
                som_pkg::CFG_REVERSE:   r_reverse   <= i_cfg_wdata[4:0];
                som_pkg::CFG_NEUTRAL_A: r_neutral_a <= i_cfg_wdata;
                som_pkg::CFG_NEUTRAL_B: r_neutral_b <= i_cfg_wdata;
                som_pkg::CFG_MIN_A:     r_min_a     <= i_cfg_wdata;
                som_pkg::CFG_MIN_B:     r_min_b     <= i_cfg_wdata;
                som_pkg::CFG_MAX_A:     r_max_a     <= i_cfg_wdata;
                som_pkg::CFG_MAX_B:     r_max_b     <= i_cfg_wdata;
            endcase
        end
    end

    // Unpack the limit registers into per-servo lanes.
    assign limits.neutral = {r_neutral_b, r_neutral_a};
    assign limits.min     = {r_min_b, r_min_a};
    assign limits.max     = {r_max_b, r_max_a};

    som_front u_front (
        .i_valid    (i_valid),
        .i_cmd      (i_data),
        .i_mix_mode (r_mix_mode),
        .i_reverse  (r_reverse),
        .i_q_status (q_status),
        .o_stall    (o_stall),
        .o_push     (push),
        .o_item     (push_item)
    );

    som_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (push_item),
        .i_pop    (pop),
        .o_item   (head_item),
        .o_status (q_status)
    );

    som_back #(
        .SERVO_COUNT (SERVO_COUNT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_item     (head_item),
        .i_limits   (limits),
        .i_stall    (i_stall),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .o_data     (o_data)
    );

`ifndef SYNTH
    // An accepted command beat is waiting in the queue on the next cycle.
    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> !q_status.empty)
        else $error("accepted command beat missing from the queue");

    // Every item taken from the queue becomes a pulse beat.
    a_pop_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> o_valid)
        else $error("popped item did not reach the output");

    // Servo 0 is always within its maximum, or pinned at its minimum.
    a_clamp0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.pulse_0 <= r_max_a[11:0]) || (o_data.pulse_0 == r_min_a[11:0]))
        else $error("servo 0 pulse outside its limits");
`endif

endmodule
